>>> design/multi_stack_transfer_engine_defines.svh
// assertion macros for the multi-stack transfer engine
// each macro expects clk and rst_n in scope
`ifndef MULTI_STACK_TRANSFER_ENGINE_DEFINES_SVH
`define MULTI_STACK_TRANSFER_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MSTE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define MSTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define MSTE_ASSERT_IMPL(lbl, ante, cons)
`define MSTE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/mste_pkg.sv
package mste_pkg;

  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int STACK_NO_W = 4;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;
  localparam int COUNT_W    = 4;
  localparam int CAP_TBL_W  = 40;
  localparam int CAP_F_W    = 5;
  localparam int CAP_FIELDS = CAP_TBL_W / CAP_F_W;

  localparam logic [COUNT_W-1:0]   STACK_COUNT_RST = 4'd8;
  localparam logic [CAP_TBL_W-1:0] CAPACITY_RST    = 40'h84_2108_4210;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_NEXT = 2'd2,
    MODE_ANY  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_BADIDX = 3'd3,
    ST_SAME   = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic load_idx;
    logic sel_dst;
    logic rd_src;
    logic dec_src_now;
    logic set_under;
    logic set_over;
    logic wr_dst;
    logic ld_pop;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  idx_err;
    logic  sel_empty;
    logic  sel_full;
  } sts_t;

endpackage

>>> design/mste_in_if.sv
interface mste_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mste_pkg::MODE_W-1:0]          mode;
  logic signed [mste_pkg::VALUE_W-1:0]  push_value;
  logic [mste_pkg::STACK_NO_W-1:0]      source_stack;
  logic [mste_pkg::STACK_NO_W-1:0]      dest_stack;

  modport source (output valid, mode, push_value, source_stack, dest_stack, input ready);
  modport sink (input valid, mode, push_value, source_stack, dest_stack, output ready);
endinterface

>>> design/mste_out_if.sv
interface mste_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mste_pkg::VALUE_W-1:0]  popped_value;
  logic [mste_pkg::STATUS_W-1:0]        status;

  modport source (output valid, popped_value, status, input ready);
  modport sink (input valid, popped_value, status, output ready);
endinterface

>>> design/mste_cfg_if.sv
interface mste_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mste_pkg::CFG_IDX_W-1:0]   index;
  logic [mste_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/mste_ram.sv
module mste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/mste_ctrl.sv
module mste_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  input  mste_pkg::sts_t  sts,
  output mste_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SRC,
    S_DST,
    S_POPRD,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.load_idx = 1'b1;
        if (sts.idx_err) begin
          state_nxt = S_RESP;
        end else if (sts.mode == mste_pkg::MODE_PUSH) begin
          state_nxt = S_DST;
        end else begin
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        if (sts.sel_empty) begin
          cmd.set_under = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_src = 1'b1;
          if (sts.mode == mste_pkg::MODE_POP) begin
            cmd.dec_src_now = 1'b1;
            state_nxt       = S_POPRD;
          end else begin
            state_nxt = S_DST;
          end
        end
      end
      S_DST: begin
        cmd.sel_dst = 1'b1;
        if (sts.sel_full) begin
          cmd.set_over = 1'b1;
        end else begin
          cmd.wr_dst = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_POPRD: begin
        cmd.ld_pop = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/mste_dp.sv
module mste_dp #(
  parameter int NUM_STACKS = 8,
  parameter int DEPTH      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mste_pkg::cmd_t                       cmd,
  output mste_pkg::sts_t                       sts,
  input  logic [mste_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [mste_pkg::VALUE_W-1:0]  in_push_value,
  input  logic [mste_pkg::STACK_NO_W-1:0]      in_source_stack,
  input  logic [mste_pkg::STACK_NO_W-1:0]      in_dest_stack,
  input  logic                                 cfg_we,
  input  logic [mste_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mste_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [mste_pkg::VALUE_W-1:0]  out_popped_value,
  output logic [mste_pkg::STATUS_W-1:0]        out_status
);

  localparam int SIDX_W = $clog2(NUM_STACKS);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_STACKS * DEPTH);
  localparam int N_W    = $clog2(NUM_STACKS + 1);
  localparam int NCMP_W = (N_W > mste_pkg::STACK_NO_W) ? N_W : mste_pkg::STACK_NO_W;
  localparam int CMP_W  = (CNT_W > mste_pkg::CAP_F_W) ? CNT_W : mste_pkg::CAP_F_W;
  localparam int VW     = mste_pkg::VALUE_W;

  // configuration
  logic [mste_pkg::COUNT_W-1:0]   stack_count_r;
  logic [mste_pkg::CAP_TBL_W-1:0] capacity_r;

  // command registers
  mste_pkg::mode_t                 mode_r;
  logic [VW-1:0]                   val_r;
  logic [mste_pkg::STACK_NO_W-1:0] src_r;
  logic [mste_pkg::STACK_NO_W-1:0] dst_r;
  logic [SIDX_W-1:0]               s_r;
  logic [SIDX_W-1:0]               d_r;
  logic [CNT_W-1:0]                cnt_s_r;
  mste_pkg::status_t               stat_r;
  logic [VW-1:0]                   popped_r;
  logic [VW-1:0]                   out_popped_r;
  mste_pkg::status_t               out_status_r;

  // fill counts
  logic [CNT_W-1:0] cnt_r   [NUM_STACKS];
  logic [CNT_W-1:0] cnt_nxt [NUM_STACKS];

  logic [CMP_W-1:0]   cap_arr [NUM_STACKS];
  logic [NCMP_W-1:0]  n_act;
  logic [NCMP_W-1:0]  src_x;
  logic [NCMP_W-1:0]  dst_x;
  mste_pkg::status_t  idx_stat;
  logic [SIDX_W-1:0]  s_nxt;
  logic [SIDX_W-1:0]  d_nxt;
  logic [SIDX_W-1:0]  sel;
  logic [CNT_W-1:0]   cnt_sel;
  logic [CMP_W-1:0]   cap_sel;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VW-1:0]     ram_rdata;

  function automatic logic [ADDR_W-1:0] slot(input logic [SIDX_W-1:0] k,
                                             input logic [CNT_W-1:0] pos);
    return ADDR_W'(k) * ADDR_W'(DEPTH) + ADDR_W'(pos);
  endfunction

  // per-stack capacity, saturated; stacks past the table have none
  for (genvar k = 0; k < NUM_STACKS; k++) begin : g_cap
    if (k < mste_pkg::CAP_FIELDS) begin : g_field
      logic [mste_pkg::CAP_F_W-1:0] raw;
      assign raw = capacity_r[mste_pkg::CAP_F_W*k +: mste_pkg::CAP_F_W];
      assign cap_arr[k] = (CMP_W'(raw) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(raw);
    end else begin : g_none
      assign cap_arr[k] = '0;
    end
  end

  // index checks
  always_comb begin
    src_x = NCMP_W'(src_r);
    dst_x = NCMP_W'(dst_r);
    if (stack_count_r == '0) begin
      n_act = NCMP_W'(1);
    end else if (NCMP_W'(stack_count_r) > NCMP_W'(NUM_STACKS)) begin
      n_act = NCMP_W'(NUM_STACKS);
    end else begin
      n_act = NCMP_W'(stack_count_r);
    end

    idx_stat = mste_pkg::ST_OK;
    s_nxt    = SIDX_W'(src_x - 1'b1);
    d_nxt    = '0;
    case (mode_r)
      mste_pkg::MODE_PUSH: begin
        d_nxt = '0;
      end
      mste_pkg::MODE_POP: begin
        s_nxt = SIDX_W'(n_act - 1'b1);
      end
      mste_pkg::MODE_NEXT: begin
        d_nxt = SIDX_W'(src_x);
        if (src_x == '0 || src_x >= n_act) begin
          idx_stat = mste_pkg::ST_BADIDX;
        end
      end
      mste_pkg::MODE_ANY: begin
        d_nxt = SIDX_W'(dst_x - 1'b1);
        if (src_x == '0 || src_x > n_act || dst_x == '0 || dst_x > n_act) begin
          idx_stat = mste_pkg::ST_BADIDX;
        end else if (src_x == dst_x) begin
          idx_stat = mste_pkg::ST_SAME;
        end
      end
      default: begin
        idx_stat = mste_pkg::ST_OK;
      end
    endcase
  end

  assign sel     = cmd.sel_dst ? d_r : s_r;
  assign cnt_sel = cnt_r[sel];
  assign cap_sel = cap_arr[sel];

  assign sts.mode      = mode_r;
  assign sts.idx_err   = (idx_stat != mste_pkg::ST_OK);
  assign sts.sel_empty = (cnt_sel == '0);
  assign sts.sel_full  = (CMP_W'(cnt_sel) >= cap_sel);

  // element store
  assign ram_we    = cmd.wr_dst;
  assign ram_waddr = slot(d_r, cnt_sel);
  assign ram_wdata = (mode_r == mste_pkg::MODE_PUSH) ? val_r : ram_rdata;
  assign ram_re    = cmd.rd_src;
  assign ram_raddr = slot(s_r, cnt_sel - 1'b1);

  mste_ram #(
    .WIDTH (VW),
    .DEPTH (NUM_STACKS * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.dec_src_now) begin
      cnt_nxt[s_r] = cnt_sel - 1'b1;
    end
    if (cmd.wr_dst) begin
      cnt_nxt[d_r] = cnt_sel + 1'b1;
      if (mode_r != mste_pkg::MODE_PUSH) begin
        cnt_nxt[s_r] = cnt_s_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_STACKS; k++) begin
        cnt_r[k] <= '0;
      end
      stack_count_r <= mste_pkg::STACK_COUNT_RST;
      capacity_r    <= mste_pkg::CAPACITY_RST;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mste_pkg::CFG_STACK_COUNT: stack_count_r <= cfg_data[mste_pkg::COUNT_W-1:0];
          mste_pkg::CFG_CAPACITY:    capacity_r    <= cfg_data[mste_pkg::CAP_TBL_W-1:0];
          default: begin
            stack_count_r <= stack_count_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= mste_pkg::mode_t'(in_mode);
      val_r  <= in_push_value;
      src_r  <= in_source_stack;
      dst_r  <= in_dest_stack;
    end
    if (cmd.load_idx) begin
      s_r      <= s_nxt;
      d_r      <= d_nxt;
      stat_r   <= idx_stat;
      popped_r <= '0;
    end
    if (cmd.rd_src) begin
      cnt_s_r <= cnt_sel;
    end
    if (cmd.set_under) begin
      stat_r <= mste_pkg::ST_UNDER;
    end
    if (cmd.set_over) begin
      stat_r <= mste_pkg::ST_OVER;
    end
    if (cmd.ld_pop) begin
      popped_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_popped_r <= popped_r;
      out_status_r <= stat_r;
    end
  end

  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;

endmodule

>>> design/multi_stack_transfer_engine.sv
// Multi-stack transfer engine: NUM_STACKS LIFO stacks of up to DEPTH 32-bit
// elements share one single-port-write, registered-read store, each with its
// own fill count and a 5-bit capacity from the capacity register (values above
// DEPTH saturate, stacks past the table have capacity zero). A command pushes
// onto stack 1, pops the last active stack, moves the top of stack i to i+1,
// or moves the top of stack i to stack j; one result (popped value and status)
// comes back per command, and a failed command changes nothing. Commands are
// handled one at a time: each is checked, then a pop or a transfer reads its
// source stack and a push or a transfer writes its destination stack, and the
// result waits for the sink; the steps are set by the single fill-count read
// port and the store's registered read, which a transfer uses in turn.
// Configuration is always ready and must only be written while idle.
`include "multi_stack_transfer_engine_defines.svh"

module multi_stack_transfer_engine #(
  parameter int NUM_STACKS = 8,
  parameter int DEPTH      = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mste_in_if.sink      in_if,
  mste_out_if.source   out_if,
  mste_cfg_if.sink     cfg_if
);

  mste_pkg::cmd_t cmd;
  mste_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;

  // sequencer: one command in flight at a time
  mste_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // counts, capacities, index checks and the element store
  mste_dp #(
    .NUM_STACKS (NUM_STACKS),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_if.mode),
    .in_push_value    (in_if.push_value),
    .in_source_stack  (in_if.source_stack),
    .in_dest_stack    (in_if.dest_stack),
    .cfg_we           (cfg_if.valid),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .out_popped_value (out_if.popped_value),
    .out_status       (out_if.status)
  );

  // handshakes
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign cfg_if.ready = 1'b1;

  // after an accepted command the engine is not ready in the next cycle
  `MSTE_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready)

  // a failed command never reports a popped value
  `MSTE_ASSERT_IMPL(a_err_zero_value, out_if.valid && out_if.status != mste_pkg::ST_OK,
                    out_if.popped_value == '0)

  // the output register is only reloaded once its previous result has gone
  `MSTE_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_if.valid || out_if.ready)

endmodule

>>> tb/multi_stack_transfer_engine_tb.sv
module multi_stack_transfer_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mste_pkg::*;

  localparam int NSTK        = 8;
  localparam int DEP         = 16;
  localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 120;   // receiver hold-off used to back the engine up
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 165;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped;
    status_t                   status;
  } stack_result_t;

  logic clk;
  logic rst_n;

  mste_in_if  in_ch ();
  mste_out_if out_ch ();
  mste_cfg_if cfg_ch ();

  multi_stack_transfer_engine #(
    .NUM_STACKS (NSTK),
    .DEPTH      (DEP)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state: own copy of the stacks and of both registers
  logic [VALUE_W-1:0]    stack_mem [NSTK][DEP];
  int unsigned           stack_fill [NSTK] = '{default: 0};
  logic [COUNT_W-1:0]    cfg_stacks = STACK_COUNT_RST;
  logic [CAP_TBL_W-1:0]  cfg_caps   = CAPACITY_RST;

  stack_result_t pending_results [$];

  // bookkeeping
  int unsigned mismatches  = 0;
  int unsigned results_got = 0;
  int unsigned cfg_writes  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned status_seen [5] = '{default: 0};

  // idling controls
  bit   idle_on     = 1'b1;
  bit   hold_active = 1'b0;
  event long_hold_go;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // stack count clamped to 1..NSTK
  function automatic int unsigned live_stacks();
    if (cfg_stacks < 1) return 1;
    if (cfg_stacks > NSTK) return NSTK;
    return cfg_stacks;
  endfunction

  // 5-bit capacity field, saturated to the stack depth; no field means no room
  function automatic int unsigned cap_of(int unsigned k);
    int unsigned c;
    if (k >= CAP_FIELDS) return 0;
    c = cfg_caps[CAP_F_W*k +: CAP_F_W];
    return (c > DEP) ? DEP : c;
  endfunction

  // full also covers a count left above a lowered capacity
  function automatic bit stack_full(int unsigned k);
    return stack_fill[k] >= cap_of(k);
  endfunction

  // move the top of stack s onto stack d, zero-based, empty source checked first
  function automatic status_t shift_top(int unsigned s, int unsigned d);
    if (stack_fill[s] == 0) return ST_UNDER;
    if (stack_full(d)) return ST_OVER;
    stack_mem[d][stack_fill[d]] = stack_mem[s][stack_fill[s] - 1];
    stack_fill[d]++;
    stack_fill[s]--;
    return ST_OK;
  endfunction

  function automatic stack_result_t apply_command(mode_t m, logic [VALUE_W-1:0] v,
                                                  logic [STACK_NO_W-1:0] s,
                                                  logic [STACK_NO_W-1:0] d);
    stack_result_t r;
    int unsigned   n;
    n = live_stacks();
    r.popped = '0;
    r.status = ST_OK;
    case (m)
      MODE_PUSH: begin
        if (stack_full(0)) begin
          r.status = ST_OVER;
        end else begin
          stack_mem[0][stack_fill[0]] = v;
          stack_fill[0]++;
        end
      end
      MODE_POP: begin
        if (stack_fill[n-1] == 0) begin
          r.status = ST_UNDER;
        end else begin
          stack_fill[n-1]--;
          r.popped = stack_mem[n-1][stack_fill[n-1]];
        end
      end
      MODE_NEXT: begin
        // dest_stack plays no part here
        if (s < 1 || s >= n) r.status = ST_BADIDX;
        else r.status = shift_top(s - 1, s);
      end
      default: begin
        // index first, then same stack, then the source/destination checks
        if (s < 1 || s > n || d < 1 || d > n) r.status = ST_BADIDX;
        else if (s == d) r.status = ST_SAME;
        else r.status = shift_top(s - 1, d - 1);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: register writes, command transfers and result checks, all sampled
  // at the rising edge; inputs only ever move on the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    stack_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;

      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        cfg_writes++;
        if (cfg_ch.index == CFG_STACK_COUNT) cfg_stacks = cfg_ch.data[COUNT_W-1:0];
        else if (cfg_ch.index == CFG_CAPACITY) cfg_caps = cfg_ch.data[CAP_TBL_W-1:0];
      end

      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        pending_results.push_back(apply_command(mode_t'(in_ch.mode), in_ch.push_value,
                                                in_ch.source_stack, in_ch.dest_stack));
      end

      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        results_got++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: popped %h status %0d", $time,
                     out_ch.popped_value, out_ch.status);
        end else begin
          want = pending_results.pop_front();
          status_seen[want.status]++;
          if (out_ch.popped_value !== want.popped || out_ch.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: popped exp %h got %h, status exp %0d got %0d",
                       $time, want.popped, out_ch.popped_value, want.status, out_ch.status);
          end
        end
      end

      // watchdog on cycles with no transfer on any channel
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                   QUIET_LIMIT, pending_results.size());
          $display("FAIL multi_stack_transfer_engine");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall after each transfer, plus the long hold-off
  // ---------------------------------------------------------------------------

  // long hold-off, counted on rising edges so the falling-edge driver reads a settled flag
  initial begin : long_hold_counter
    forever begin
      @(long_hold_go);
      @(posedge clk);
      hold_active = 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      hold_active = 1'b0;
    end
  end

  int unsigned sink_seen = 0;
  int unsigned sink_wait = 0;

  always @(negedge clk) begin : result_sink
    if (results_got != sink_seen) begin
      sink_seen = results_got;
      sink_wait = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else if (sink_wait != 0) begin
      out_ch.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // called on a falling edge; returns on the falling edge after the transfer with
  // valid left high, so a back-to-back command never drops and raises it in one step
  task automatic send_cmd(input mode_t m, input logic [VALUE_W-1:0] v,
                          input logic [STACK_NO_W-1:0] s, input logic [STACK_NO_W-1:0] d);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.push_value   <= v;
    in_ch.source_stack <= s;
    in_ch.dest_stack   <= d;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // sender stops and waits for every outstanding result, then a short margin
  task automatic wait_engine_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // both registers, only once the engine has gone quiet; the upper bits of the
  // stack count word are random so every data bit gets exercised
  task automatic set_config(input logic [COUNT_W-1:0] count, input logic [CAP_TBL_W-1:0] caps);
    logic [CFG_DATA_W-1:0] word;
    wait_engine_idle();
    word = CFG_DATA_W'({$urandom, $urandom});
    word[COUNT_W-1:0] = count;
    write_reg(CFG_STACK_COUNT, word);
    write_reg(CFG_CAPACITY, caps);
    cfg_ch.valid <= 1'b0;
  endtask

  // a random 1-based stack among the first n that holds something, else any of them
  function automatic int unsigned loaded_stack(int unsigned n);
    int unsigned picks [$];
    for (int k = 0; k < n; k++)
      if (stack_fill[k] != 0) picks.push_back(k + 1);
    if (picks.size() == 0) return $urandom_range(1, n);
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  // mostly well-formed commands aimed at live, loaded stacks, the rest raw noise
  task automatic send_random_cmd();
    int unsigned n, roll, s, d;
    mode_t       m;
    n    = live_stacks();
    roll = $urandom_range(0, 99);
    m    = (roll < 35) ? MODE_PUSH : (roll < 58) ? MODE_POP :
           (roll < 78) ? MODE_NEXT : MODE_ANY;
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom_range(0, 15);
      d = $urandom_range(0, 15);
    end else begin
      s = $urandom_range(0, 1) ? loaded_stack(n) : $urandom_range(1, n);
      d = $urandom_range(1, n);
      if (m == MODE_NEXT && s >= n && n > 1) s = $urandom_range(1, n - 1);
    end
    send_cmd(m, $urandom, s[STACK_NO_W-1:0], d[STACK_NO_W-1:0]);
  endtask

  // per-stack capacity word: 0 reset, 1 all zero, 2 all ones, 3 small, else anything
  function automatic logic [CAP_TBL_W-1:0] caps_for(int unsigned style);
    logic [CAP_TBL_W-1:0] caps;
    case (style)
      0: caps = CAPACITY_RST;
      1: caps = '0;
      2: caps = '1;
      default: begin
        for (int k = 0; k < CAP_FIELDS; k++)
          caps[CAP_F_W*k +: CAP_F_W] = CAP_F_W'((style == 3) ? $urandom_range(0, 4)
                                                             : $urandom_range(0, 31));
      end
    endcase
    return caps;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: every mode, value extremes, the plain failure cases
  task automatic test_basic_modes();
    send_cmd(MODE_POP,  32'h0,         4'd0, 4'd0);   // last stack empty after reset
    send_cmd(MODE_PUSH, 32'h7FFF_FFFF, 4'd0, 4'd0);
    send_cmd(MODE_PUSH, 32'h8000_0000, 4'd0, 4'd0);
    send_cmd(MODE_PUSH, 32'h0,         4'd0, 4'd0);
    send_cmd(MODE_PUSH, 32'hFFFF_FFFF, 4'd0, 4'd0);
    send_cmd(MODE_NEXT, 32'h0,         4'd1, 4'd15);  // destination field ignored
    send_cmd(MODE_ANY,  32'h0,         4'd2, 4'd8);
    send_cmd(MODE_POP,  32'h0,         4'd0, 4'd0);   // comes back off stack 8
    send_cmd(MODE_ANY,  32'h0,         4'd3, 4'd3);   // same stack
    send_cmd(MODE_ANY,  32'h0,         4'd5, 4'd6);   // empty source
  endtask

  // stack numbers outside the live range for both transfer modes
  task automatic test_bad_index();
    send_cmd(MODE_NEXT, 32'h0, 4'd0,  4'd1);
    send_cmd(MODE_NEXT, 32'h0, 4'd8,  4'd1);   // last stack has no next
    send_cmd(MODE_NEXT, 32'h0, 4'd15, 4'd1);
    send_cmd(MODE_ANY,  32'h0, 4'd0,  4'd2);
    send_cmd(MODE_ANY,  32'h0, 4'd1,  4'd0);
    send_cmd(MODE_ANY,  32'h0, 4'd9,  4'd1);
    send_cmd(MODE_ANY,  32'h0, 4'd1,  4'd15);
  endtask

  // clamped stack counts, zero and saturated capacities, count above a lowered capacity
  task automatic test_capacity_edges();
    logic [CAP_TBL_W-1:0] caps;
    caps = '1;                 // fields of 31 saturate to the depth
    caps[4:0] = 5'd1;          // stack 1 lowered below what it holds
    caps[9:5] = 5'd0;          // stack 2 can never take anything
    set_config(4'd0, caps);    // count of zero behaves as one stack
    send_cmd(MODE_PUSH, 32'h1234_5678, 4'd0, 4'd0);
    send_cmd(MODE_NEXT, 32'h0,         4'd1, 4'd2);
    send_cmd(MODE_POP,  32'h0,         4'd0, 4'd0);
    set_config(4'd15, caps);   // count above the stack total behaves as all of them
    send_cmd(MODE_ANY,  32'h0, 4'd1, 4'd2);
    send_cmd(MODE_NEXT, 32'h0, 4'd1, 4'd0);
    send_cmd(MODE_ANY,  32'h0, 4'd1, 4'd3);
    send_cmd(MODE_POP,  32'h0, 4'd0, 4'd0);
    send_cmd(MODE_ANY,  32'h0, 4'd3, 4'd1);
  endtask

  // receiver holds off for a long stretch while commands keep coming back to back
  task automatic test_backpressure();
    set_config(STACK_COUNT_RST, CAPACITY_RST);
    idle_on = 1'b0;
    -> long_hold_go;
    repeat (40) send_random_cmd();
    idle_on = 1'b1;
  endtask

  // phases of random commands, each under its own register settings; every
  // phase change makes the sender pause until all results are back
  task automatic test_random_phases();
    int unsigned counts [PHASES] = '{8, 0, 15, 1, 2, 3, 8, 5, 12, 4};
    int unsigned styles [PHASES] = '{0, 1, 2, 3, 4, 3, 4, 0, 4, 3};
    for (int p = 0; p < PHASES; p++) begin
      set_config(COUNT_W'(counts[p]), caps_for(styles[p]));
      idle_on = (p % 3 != 2);   // every third phase runs flat out
      repeat (PHASE_ITEMS) send_random_cmd();
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = '0;
    in_ch.push_value   = '0;
    in_ch.source_stack = '0;
    in_ch.dest_stack   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_modes();
    test_bad_index();
    test_capacity_edges();
    test_backpressure();
    test_random_phases();

    // drain, then a margin for anything stray
    wait_engine_idle();
    repeat (16) @(negedge clk);

    $display("covered %0d results over %0d register writes, with long and random stalls",
             results_got, cfg_writes);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, bad index %0d, same stack %0d",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_BADIDX], status_seen[ST_SAME]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS multi_stack_transfer_engine");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("FAIL multi_stack_transfer_engine");
    end
    $finish;
  end

endmodule
